// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/fatlb_pkg.sv =====
`timescale 1ns / 1ps

package fatlb_pkg;

    localparam int LINES    = 128;
    localparam int VPN_BITS = 36;
    localparam int PPN_BITS = 20;
    localparam int OFF_BITS = 12;
    localparam int CMD_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CMP  = 2'b10
    } t_state;

    // one translation held by a cell
    typedef struct packed {
        logic                valid;
        logic [VPN_BITS-1:0] tag;
        logic [PPN_BITS-1:0] ppn;
    } t_entry;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic cmp_en;
        logic commit;
        logic flush;
        logic fill;
        logic lookup_hit;
    } t_cell_ctl;

endpackage

// ===== rtl/core/fatlb_if.sv =====
`timescale 1ns / 1ps

interface fatlb_req_if;
    import fatlb_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] cmd;
    logic [VPN_BITS-1:0] virt_page;
    logic [OFF_BITS-1:0] byte_offset;
    logic [PPN_BITS-1:0] fill_phys_page;

    modport source (output valid, cmd, virt_page, byte_offset, fill_phys_page, input ready);
    modport sink   (input valid, cmd, virt_page, byte_offset, fill_phys_page, output ready);
endinterface

interface fatlb_rsp_if;
    import fatlb_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [PPN_BITS-1:0] phys_page;
    logic [OFF_BITS-1:0] phys_offset;

    modport source (output valid, hit, phys_page, phys_offset, input ready);
    modport sink   (input valid, hit, phys_page, phys_offset, output ready);
endinterface

// ===== rtl/core/fatlb_cell.sv =====
`timescale 1ns / 1ps

module fatlb_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fatlb_pkg::t_cell_ctl          i_ctl,
    input  logic [fatlb_pkg::VPN_BITS-1:0] i_vpn,
    input  fatlb_pkg::t_entry             i_up,
    input  logic                          i_above,
    output fatlb_pkg::t_entry             o_entry,
    output logic                          o_above,
    output logic                          o_sel,
    output logic [fatlb_pkg::PPN_BITS-1:0] o_sel_ppn
);
    import fatlb_pkg::*;

    logic                r_valid;
    logic [VPN_BITS-1:0] r_tag;
    logic [PPN_BITS-1:0] r_ppn;
    logic                r_match;
    logic                w_shift;

    // shift when filling, or when the hit sits at or below this cell
    assign w_shift   = i_ctl.fill || (i_ctl.lookup_hit && !i_above);
    assign o_above   = i_above | r_match;
    assign o_sel     = r_match & ~i_above;
    assign o_sel_ppn = o_sel ? r_ppn : '0;
    assign o_entry   = '{valid: r_valid, tag: r_tag, ppn: r_ppn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_match <= r_valid && (r_tag == i_vpn);
            end
            if (i_ctl.commit) begin
                if (i_ctl.flush) begin
                    r_valid <= 1'b0;
                end else if (w_shift) begin
                    r_valid <= i_up.valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && !i_ctl.flush && w_shift) begin
            r_tag <= i_up.tag;
            r_ppn <= i_up.ppn;
        end
    end

endmodule

// ===== rtl/core/fully_assoc_tlb_lru_core.sv =====
`timescale 1ns / 1ps

// Fully associative TLB with LRU replacement, built as a recency stack: a row of
// LINES cells where the top cell holds the most recent translation and cell 0 the
// least recent. Each request transaction carries a command: lookup, fill or flush.
// A lookup compares the virtual page against every valid cell; the match nearest
// the top wins, its physical page is returned with the page offset, and it moves to
// the top while the cells above it slide down one place. A lookup miss returns hit
// low, page zero and the offset, and leaves the order alone. A fill pushes the new
// translation in at the top and drops the least recent one out of cell 0; it
// returns the filled page and the offset. A flush clears every valid bit and
// returns all zeros; the unused command returns all zeros and changes nothing.
// Every request gives exactly one response transaction. Each transaction first
// compares the tag in all cells and registers the match flags, then resolves the
// highest match along the cell chain and shifts the stack. The response sits in
// an output register; when it is not taken the resolve step waits for it. A new
// request is taken only once the previous one has committed.

`include "assert_macros.svh"

module fully_assoc_tlb_lru_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fatlb_req_if.sink   i_req,
    fatlb_rsp_if.source o_rsp
);
    import fatlb_pkg::*;

    // control
    t_state r_state;
    logic   w_accept;
    logic   w_out_free;
    logic   w_commit;

    // captured request
    logic [CMD_BITS-1:0] r_cmd;
    logic [VPN_BITS-1:0] r_vpn;
    logic [OFF_BITS-1:0] r_off;
    logic [PPN_BITS-1:0] r_fill;

    // response register
    logic                r_out_valid;
    logic                r_out_hit;
    logic [PPN_BITS-1:0] r_out_ppn;
    logic [OFF_BITS-1:0] r_out_off;

    // cell chain wiring
    t_cell_ctl           w_ctl;
    t_entry              w_entry   [LINES];
    logic                w_above   [LINES];
    logic [LINES-1:0]    w_sel;
    logic [PPN_BITS-1:0] w_sel_ppn [LINES];
    logic [PPN_BITS-1:0] w_hit_ppn;
    logic                w_any_hit;
    logic                w_is_lookup;
    logic                w_is_fill;
    logic                w_is_flush;
    t_entry              w_new_entry;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_commit   = (r_state == S_CMP) && w_out_free;

    assign i_req.ready = (r_state == S_IDLE);

    assign w_is_lookup = (r_cmd == CMD_LOOKUP);
    assign w_is_fill   = (r_cmd == CMD_FILL);
    assign w_is_flush  = (r_cmd == CMD_FLUSH);

    // bottom of the chain has seen every match flag
    assign w_any_hit = w_above[0];

    assign w_ctl = '{
        cmp_en:     w_accept,
        commit:     w_commit,
        flush:      w_is_flush,
        fill:       w_is_fill,
        lookup_hit: w_is_lookup && w_any_hit
    };

    // only one cell can own the selection, so an or across them is the mux
    always_comb begin
        w_hit_ppn = '0;
        for (int k = 0; k < LINES; k++) begin
            w_hit_ppn = w_hit_ppn | w_sel_ppn[k];
        end
    end

    // entry pushed into the top cell: the hit entry again, or the new fill
    assign w_new_entry = '{
        valid: 1'b1,
        tag:   r_vpn,
        ppn:   w_is_fill ? r_fill : w_hit_ppn
    };

    // the recency stack
    for (genvar g = 0; g < LINES; g++) begin : g_cell
        t_entry w_up;
        logic   w_in_above;
        logic   w_sel_bit;

        if (g == LINES - 1) begin : g_top
            assign w_up       = w_new_entry;
            assign w_in_above = 1'b0;
        end else begin : g_mid
            assign w_up       = w_entry[g+1];
            assign w_in_above = w_above[g+1];
        end

        fatlb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_vpn     (i_req.virt_page),
            .i_up      (w_up),
            .i_above   (w_in_above),
            .o_entry   (w_entry[g]),
            .o_above   (w_above[g]),
            .o_sel     (w_sel_bit),
            .o_sel_ppn (w_sel_ppn[g])
        );

        assign w_sel[g] = w_sel_bit;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the request transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_req.cmd;
            r_vpn  <= i_req.virt_page;
            r_off  <= i_req.byte_offset;
            r_fill <= i_req.fill_phys_page;
        end
    end

    // build the response
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            case (r_cmd)
                CMD_LOOKUP: begin
                    r_out_hit <= w_any_hit;
                    r_out_ppn <= w_any_hit ? w_hit_ppn : '0;
                    r_out_off <= r_off;
                end
                CMD_FILL: begin
                    r_out_hit <= 1'b0;
                    r_out_ppn <= r_fill;
                    r_out_off <= r_off;
                end
                default: begin
                    // flush and the unused code
                    r_out_hit <= 1'b0;
                    r_out_ppn <= '0;
                    r_out_off <= '0;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.phys_page   = r_out_ppn;
    assign o_rsp.phys_offset = r_out_off;

    // at most one cell wins the priority resolve
    `ASSERT_ALWAYS(a_sel_onehot, $onehot0(w_sel), "more than one cell selected")
    // a taken request moves the sequencer into the compare cycle
    `ASSERT_CLK(a_accept_to_cmp, w_accept |=> (r_state == S_CMP), "accept did not start compare")
    // a response only appears after a compare cycle
    `ASSERT_CLK(a_rsp_after_cmp, $rose(r_out_valid) |-> $past(r_state == S_CMP),
        "response without compare")
    // a fill leaves a valid entry in the top cell
    `ASSERT_CLK(a_fill_top_valid, (w_commit && w_is_fill) |=> w_entry[LINES-1].valid,
        "fill did not land in top cell")

endmodule
